// File: src/mi3_pkg.sv
// shared types, widths and tables for the 3x3 matrix inverse
package mi3_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ENTRY_W     = 32;
   localparam int THR_W       = 16;
   localparam int CO_W        = 2 * ENTRY_W;
   localparam int PROD_W      = ENTRY_W + CO_W;
   localparam int DET_W       = PROD_W + 2;
   localparam int MAG_W       = DET_W;
   localparam int DEN_W       = MAG_W + 1;
   localparam int QUO_W       = 32;
   localparam int NUM_SHIFT   = 2 * FRAC_BITS + 1;
   localparam int NUM_W       = ((CO_W + NUM_SHIFT) > MAG_W ? (CO_W + NUM_SHIFT) : MAG_W) + 1;
   localparam int CMP_W       = DEN_W + QUO_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1);
   localparam logic [QUO_W-1:0]   POS_MAX   = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0]   NEG_MAX   = {1'b1, {(QUO_W-1){1'b0}}};

   // cofactor k = m[A]*m[B] - m[C]*m[D], matrix row major
   localparam int CO_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int CO_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int CO_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int CO_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a11;
      logic signed [ENTRY_W-1:0] a12;
      logic signed [ENTRY_W-1:0] a13;
      logic signed [ENTRY_W-1:0] a21;
      logic signed [ENTRY_W-1:0] a22;
      logic signed [ENTRY_W-1:0] a23;
      logic signed [ENTRY_W-1:0] a31;
      logic signed [ENTRY_W-1:0] a32;
      logic signed [ENTRY_W-1:0] a33;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] r11;
      logic signed [ENTRY_W-1:0] r12;
      logic signed [ENTRY_W-1:0] r13;
      logic signed [ENTRY_W-1:0] r21;
      logic signed [ENTRY_W-1:0] r22;
      logic signed [ENTRY_W-1:0] r23;
      logic signed [ENTRY_W-1:0] r31;
      logic signed [ENTRY_W-1:0] r32;
      logic signed [ENTRY_W-1:0] r33;
      logic                      singular;
   } rsp_type;

   // classified matrix handed from front to back
   typedef struct packed {
      logic [8:0][ENTRY_W-1:0] m;
      logic [8:0][CO_W-1:0]    co;
      logic [MAG_W-1:0]        mag;
      logic                    dneg;
      logic                    singular;
   } work_type;

endpackage

// File: src/mi3_front.sv
// front: takes requests, forms cofactors and determinant, flags singular matrices
module mi3_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mi3_pkg::THR_W-1:0]     csr_wdata,
   input  logic                          in_push,
   input  mi3_pkg::req_type              in_data,
   output logic                          in_full,
   input  logic                          q_full,
   output logic                          q_push,
   output mi3_pkg::work_type             q_data
);

   localparam int EntW = mi3_pkg::ENTRY_W;
   localparam int CoW  = mi3_pkg::CO_W;
   localparam int DetW = mi3_pkg::DET_W;
   localparam int MagW = mi3_pkg::MAG_W;
   localparam int SumW = mi3_pkg::PROD_W;

   logic [mi3_pkg::THR_W-1:0] thr_ff;
   logic [6:0]                v_ff;
   logic                      en;

   logic signed [EntW-1:0]   m_in   [9];
   logic signed [EntW-1:0]   m1_ff  [9];
   logic signed [EntW-1:0]   m2_ff  [9];
   logic signed [EntW-1:0]   m3_ff  [9];
   logic signed [EntW-1:0]   m4_ff  [9];
   logic signed [EntW-1:0]   m5_ff  [9];
   logic signed [EntW-1:0]   m6_ff  [9];
   logic signed [CoW-1:0]    p2_ff  [18];
   logic signed [CoW-1:0]    c3_ff  [9];
   logic signed [CoW-1:0]    c4_ff  [9];
   logic signed [CoW-1:0]    c5_ff  [9];
   logic signed [CoW-1:0]    c6_ff  [9];
   logic signed [CoW-1:0]    phi_ff [3];
   logic signed [CoW:0]      plo_ff [3];
   logic signed [SumW-1:0]   t5_ff  [3];
   logic signed [DetW-1:0]   det_ff;
   logic [MagW-1:0]          mag;
   mi3_pkg::work_type        fr_ff;

   assign en      = !(v_ff[6] && q_full);
   assign in_full = !en;
   assign q_push  = v_ff[6] && en;
   assign q_data  = fr_ff;

   assign m_in[0] = in_data.a11;
   assign m_in[1] = in_data.a12;
   assign m_in[2] = in_data.a13;
   assign m_in[3] = in_data.a21;
   assign m_in[4] = in_data.a22;
   assign m_in[5] = in_data.a23;
   assign m_in[6] = in_data.a31;
   assign m_in[7] = in_data.a32;
   assign m_in[8] = in_data.a33;

   assign mag = det_ff[DetW-1] ? MagW'(-det_ff) : MagW'(det_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::THR_RESET;
         v_ff   <= '0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (en) begin
            v_ff <= {v_ff[5:0], in_push};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            m1_ff[k] <= m_in[k];
            m2_ff[k] <= m1_ff[k];
            m3_ff[k] <= m2_ff[k];
            m4_ff[k] <= m3_ff[k];
            m5_ff[k] <= m4_ff[k];
            m6_ff[k] <= m5_ff[k];
            p2_ff[2*k]   <= m1_ff[mi3_pkg::CO_A[k]] * m1_ff[mi3_pkg::CO_B[k]];
            p2_ff[2*k+1] <= m1_ff[mi3_pkg::CO_C[k]] * m1_ff[mi3_pkg::CO_D[k]];
            c3_ff[k] <= p2_ff[2*k] - p2_ff[2*k+1];
            c4_ff[k] <= c3_ff[k];
            c5_ff[k] <= c4_ff[k];
            c6_ff[k] <= c5_ff[k];
         end
         // first-row expansion, each 32x64 product split in two halves
         for (int k = 0; k < 3; k++) begin
            phi_ff[k] <= m3_ff[k] * $signed(c3_ff[3*k][CoW-1:EntW]);
            plo_ff[k] <= m3_ff[k] * $signed({1'b0, c3_ff[3*k][EntW-1:0]});
            t5_ff[k]  <= $signed({phi_ff[k], {EntW{1'b0}}}) + SumW'(plo_ff[k]);
         end
         det_ff <= DetW'(t5_ff[0]) + DetW'(t5_ff[1]) + DetW'(t5_ff[2]);
         for (int k = 0; k < 9; k++) begin
            fr_ff.m[k]  <= m6_ff[k];
            fr_ff.co[k] <= c6_ff[k];
         end
         fr_ff.mag      <= mag;
         fr_ff.dneg     <= det_ff[DetW-1];
         fr_ff.singular <= mag <= (MagW'(thr_ff) << (2 * mi3_pkg::FRAC_BITS));
      end
   end

endmodule

// File: src/mi3_queue.sv
// short queue between the front and the back
module mi3_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mi3_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output mi3_pkg::work_type pop_data
);

   localparam int Depth = mi3_pkg::QUEUE_DEPTH;
   localparam int PtrW  = mi3_pkg::QPTR_W;

   mi3_pkg::work_type  mem_ff [Depth];
   logic [PtrW-1:0]    wr_ff;
   logic [PtrW-1:0]    rd_ff;
   logic [PtrW:0]      cnt_ff;
   logic               do_push;
   logic               do_pop;

   assign full     = cnt_ff == (PtrW+1)'(Depth);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: src/mi3_back.sv
// back: nine pipelined restoring dividers, saturation and the response queue
module mi3_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  mi3_pkg::work_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mi3_pkg::rsp_type  rsp_data
);

   localparam int EntW = mi3_pkg::ENTRY_W;
   localparam int CoW  = mi3_pkg::CO_W;
   localparam int MagW = mi3_pkg::MAG_W;
   localparam int DenW = mi3_pkg::DEN_W;
   localparam int NumW = mi3_pkg::NUM_W;
   localparam int CmpW = mi3_pkg::CMP_W;
   localparam int QuoW = mi3_pkg::QUO_W;
   localparam int OutDepth = 2;
   localparam int OptrW = $clog2(OutDepth);

   logic en;
   logic b1_v_ff, b2_v_ff;

   // stage 1: magnitudes and signs of the cofactors
   logic [CoW-1:0]  absc1_ff [9];
   logic [8:0]      neg1_ff;
   logic [MagW-1:0] mag1_ff;
   logic [EntW-1:0] m1_ff [9];
   logic            sing1_ff;

   // stage 2: dividends and divisor
   logic [NumW-1:0] num2_ff [9];
   logic [DenW-1:0] den2_ff;
   logic [8:0]      neg2_ff;
   logic [EntW-1:0] m2_ff [9];
   logic            sing2_ff;

   // division stages, stage 0 holds the overflow check
   logic            dv_ff   [QuoW+1];
   logic [NumW-1:0] rem_ff  [QuoW+1][9];
   logic [QuoW-1:0] quo_ff  [QuoW+1][9];
   logic [8:0]      ovf_ff  [QuoW+1];
   logic [8:0]      neg_ff  [QuoW+1];
   logic [DenW-1:0] den_ff  [QuoW+1];
   logic [EntW-1:0] md_ff   [QuoW+1][9];
   logic            sing_ff [QuoW+1];

   mi3_pkg::rsp_type  res;
   logic [EntW-1:0]   r [9];
   mi3_pkg::rsp_type  oq_ff [OutDepth];
   logic [OptrW-1:0]  owr_ff;
   logic [OptrW-1:0]  ord_ff;
   logic [OptrW:0]    ocnt_ff;
   logic              o_full;
   logic              o_push;
   logic              o_pop;

   assign o_full    = ocnt_ff == (OptrW+1)'(OutDepth);
   assign en        = !(dv_ff[QuoW] && o_full);
   assign q_pop     = !q_empty && en;
   assign o_push    = dv_ff[QuoW] && en;
   assign rsp_empty = ocnt_ff == '0;
   assign o_pop     = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         b1_v_ff  <= q_pop;
         b2_v_ff  <= b1_v_ff;
         dv_ff[0] <= b2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            absc1_ff[k] <= q_data.co[k][CoW-1] ? -q_data.co[k] : q_data.co[k];
            neg1_ff[k]  <= q_data.co[k][CoW-1] ^ q_data.dneg;
            m1_ff[k]    <= q_data.m[k];
            num2_ff[k]  <= (NumW'(absc1_ff[k]) << mi3_pkg::NUM_SHIFT) + NumW'(mag1_ff);
            m2_ff[k]    <= m1_ff[k];
            rem_ff[0][k] <= num2_ff[k];
            quo_ff[0][k] <= '0;
            ovf_ff[0][k] <= CmpW'(num2_ff[k]) >= (CmpW'(den2_ff) << QuoW);
            md_ff[0][k]  <= m2_ff[k];
         end
         mag1_ff    <= q_data.mag;
         sing1_ff   <= q_data.singular;
         den2_ff    <= DenW'(mag1_ff) << 1;
         neg2_ff    <= neg1_ff;
         sing2_ff   <= sing1_ff;
         neg_ff[0]  <= neg2_ff;
         den_ff[0]  <= den2_ff;
         sing_ff[0] <= sing2_ff;
      end
   end

   for (genvar s = 1; s <= QuoW; s++) begin : g_div
      localparam int Bit = QuoW - s;
      logic [CmpW-1:0] step;
      logic [NumW-1:0] rem_in [9];
      logic [QuoW-1:0] quo_in [9];

      assign step = CmpW'(den_ff[s-1]) << Bit;

      always_comb begin
         for (int k = 0; k < 9; k++) begin
            quo_in[k] = quo_ff[s-1][k];
            if (CmpW'(rem_ff[s-1][k]) >= step) begin
               rem_in[k]      = NumW'(CmpW'(rem_ff[s-1][k]) - step);
               quo_in[k][Bit] = 1'b1;
            end else begin
               rem_in[k] = rem_ff[s-1][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (en) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int k = 0; k < 9; k++) begin
               rem_ff[s][k] <= rem_in[k];
               quo_ff[s][k] <= quo_in[k];
               md_ff[s][k]  <= md_ff[s-1][k];
            end
            ovf_ff[s]  <= ovf_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            den_ff[s]  <= den_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // saturate, apply sign, or pass the matrix through when singular
   always_comb begin
      logic [QuoW-1:0] lim;
      logic [QuoW-1:0] qm;
      for (int k = 0; k < 9; k++) begin
         lim = neg_ff[QuoW][k] ? mi3_pkg::NEG_MAX : mi3_pkg::POS_MAX;
         qm  = (ovf_ff[QuoW][k] || quo_ff[QuoW][k] > lim) ? lim : quo_ff[QuoW][k];
         if (sing_ff[QuoW]) begin
            r[k] = md_ff[QuoW][k];
         end else begin
            r[k] = EntW'(neg_ff[QuoW][k] ? -qm : qm);
         end
      end
      res.r11      = r[0];
      res.r12      = r[1];
      res.r13      = r[2];
      res.r21      = r[3];
      res.r22      = r[4];
      res.r23      = r[5];
      res.r31      = r[6];
      res.r32      = r[7];
      res.r33      = r[8];
      res.singular = sing_ff[QuoW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (o_push) begin
            owr_ff <= owr_ff + 1'b1;
         end
         if (o_pop) begin
            ord_ff <= ord_ff + 1'b1;
         end
         ocnt_ff <= ocnt_ff + (OptrW+1)'(o_push) - (OptrW+1)'(o_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (o_push) begin
         oq_ff[owr_ff] <= res;
      end
   end

endmodule

// File: src/matrix3x3_inverse.sv
// 3x3 matrix inverse over signed Q16.16 entries: takes one matrix per clock unless
// a full queue stalls it. A request goes through a seven-stage front (cofactor and
// determinant multipliers, singular test), a four-entry queue, then a back of two
// set-up stages and 33 division stages, nine lanes side by side: an overflow check,
// then one restoring step and quotient bit per stage. Entries are rounded to nearest,
// ties away from zero, and saturated; a matrix whose determinant magnitude is at or
// below csr_wdata (units of 2^-16, reset 1) comes back unchanged with singular set.
module matrix3x3_inverse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [mi3_pkg::THR_W-1:0] csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  mi3_pkg::req_type          req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output mi3_pkg::rsp_type          rsp_data
);

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   mi3_pkg::work_type q_in;
   mi3_pkg::work_type q_out;

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_push   (req_push),
      .in_data   (req_data),
      .in_full   (req_full),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   mi3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/mi3_checker.sv
// port-level checks for the matrix inverse, bound to the top level
module mi3_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input mi3_pkg::rsp_type rsp_data
);

   // reset drains every stage and queue
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response waiting after reset");

   a_ready_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting response changed");

endmodule

bind matrix3x3_inverse mi3_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
